// ----- sv/psda_pkg.sv -----
`default_nettype none

package psda_pkg;

   // Fixed point format of one coordinate (signed Q12.12 at the default).
   localparam int COORD_BITS = 24;

   // Default width of the running path length.
   localparam int TOTAL_BITS_DEF = 40;

   // Width of the distance field on the result channel (unsigned Q28.12).
   localparam int DIST_BITS = 40;

   // A coordinate difference has a magnitude below 2^COORD_BITS, so the sum of
   // three squares fits in 2*COORD_BITS+2 bits and its root in half of that.
   localparam int RAD_BITS  = 2 * COORD_BITS + 2;
   localparam int ROOT_BITS = RAD_BITS / 2;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCUMULATE_MODE   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THREE_DIMENSIONAL = CSR_INDEX_BITS'(1);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic signed [COORD_BITS-1:0] z_coord;
      logic                         first_point;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance_out;
      logic                 total_saturated;
   } rsp_type;

   // Status of the square root unit toward its controller.
   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

endpackage

`default_nettype wire

// ----- sv/psda_sqrt.sv -----
`default_nettype none

module psda_sqrt
   import psda_pkg::*;
#(
   parameter int RAD_W = psda_pkg::RAD_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [RAD_W-1:0]      radicand,
   output sqrt_status_type            status,
   output logic      [RAD_W/2-1:0]    root
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff,  rad_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;
   logic              fits;

   // One root bit per cycle: bring down the next two radicand bits, try the
   // root with a one appended, keep the bit if the trial fits.
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign fits      = (rem_shift >= trial);

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = fits ? (rem_shift - trial) : rem_shift;
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("square root restarted while busy");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (cnt_ff == CNT_W'(1)) && !start |=> done_ff && !busy_ff)
      else $error("square root did not finish after its last step");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("square root busy with an exhausted step count");

endmodule

`default_nettype wire

// ----- sv/path_step_distance_accumulator.sv -----
// Path step distance accumulator. Each request carries one point (signed
// fixed point x, y, z) and a first_point flag; each request yields exactly one
// response with the Euclidean distance to the previous point, floor of the
// square root of dx^2+dy^2+dz^2, in unsigned fixed point with the same number
// of fraction bits, or in accumulate mode the running path length, which
// saturates at all ones until the next first point. A first point returns 0
// and restarts the total; before any first point the previous point is the
// origin. Register 0 (accumulate_mode, reset 0) selects the running length,
// register 1 (three_dimensional, reset 1) includes z. Write registers only
// while no request is in flight. One request is processed at a time: the
// next request is taken only after the response of the last one has gone
// into the output register. A step is dominated by the digit-serial square
// root that yields one root bit per cycle; the three squares share one
// multiplier. A first point skips the square and root phases and goes
// straight to the finish state. The response sits in an output register,
// so the next request is accepted while a response is stalled.
`default_nettype none

module path_step_distance_accumulator
   import psda_pkg::*;
#(
   parameter int TOTAL_BITS = psda_pkg::TOTAL_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_payload,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_payload,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic                      csr_wdata
);

   // Controller states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SQUARE = 2'd1;
   localparam logic [1:0] ST_ROOT   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // Square phase steps: difference for x, y, z in steps 0..2, square one
   // step later, add one step after that; the last step starts the root.
   localparam int         STEP_BITS = 3;
   localparam logic [STEP_BITS-1:0] STEP_X    = STEP_BITS'(0);
   localparam logic [STEP_BITS-1:0] STEP_Y    = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] STEP_Z    = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] STEP_SQZ  = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(4);

   localparam int PROD_BITS = 2 * COORD_BITS;

   // Control and configuration.
   logic [1:0]              state_ff,  state_in;
   logic [STEP_BITS-1:0]    step_ff,   step_in;
   logic                    accumulate_mode_ff;
   logic                    three_dimensional_ff;

   // Point store and datapath.
   req_type                 cur_ff,    cur_in;
   logic [COORD_BITS-1:0]   prev_x_ff, prev_x_in;
   logic [COORD_BITS-1:0]   prev_y_ff, prev_y_in;
   logic [COORD_BITS-1:0]   prev_z_ff, prev_z_in;
   logic [COORD_BITS-1:0]   mag_ff,    mag_in;
   logic [PROD_BITS-1:0]    prod_ff,   prod_in;
   logic [RAD_BITS-1:0]     rad_ff,    rad_in;
   logic [ROOT_BITS-1:0]    dist_ff,   dist_in;
   logic [TOTAL_BITS-1:0]   total_ff,  total_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff,       rsp_in;

   logic                    req_accept;
   logic                    rsp_free;
   logic                    sqrt_start;
   logic [RAD_BITS-1:0]     rad_sum;
   sqrt_status_type         sqrt_status;
   logic [ROOT_BITS-1:0]    sqrt_root;

   logic [COORD_BITS-1:0]   cur_sel;
   logic [COORD_BITS-1:0]   prev_sel;
   logic [COORD_BITS:0]     diff;
   logic [COORD_BITS:0]     diff_neg;
   logic [TOTAL_BITS:0]     total_sum;
   logic [TOTAL_BITS-1:0]   total_next;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // Configuration writes; drop unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         accumulate_mode_ff   <= 1'b0;
         three_dimensional_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACCUMULATE_MODE:   accumulate_mode_ff   <= csr_wdata;
            CSR_THREE_DIMENSIONAL: three_dimensional_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pick the axis whose difference is formed in this step.
   always_comb begin
      case (step_ff)
         STEP_X: begin
            cur_sel  = cur_ff.x_coord;
            prev_sel = prev_x_ff;
         end
         STEP_Y: begin
            cur_sel  = cur_ff.y_coord;
            prev_sel = prev_y_ff;
         end
         default: begin
            cur_sel  = cur_ff.z_coord;
            prev_sel = prev_z_ff;
         end
      endcase
   end

   // Signed difference in one extra bit; its magnitude always fits the
   // coordinate width.
   assign diff     = {cur_sel[COORD_BITS-1], cur_sel} - {prev_sel[COORD_BITS-1], prev_sel};
   assign diff_neg = (COORD_BITS + 1)'(0) - diff;

   // Running sum plus the last square goes straight into the root unit.
   assign rad_sum    = rad_ff + RAD_BITS'(prod_ff);
   assign sqrt_start = (state_ff == ST_SQUARE) && (step_ff == STEP_LAST);

   // Saturating total: a carry out of the add means the sum passed all ones.
   assign total_sum = {1'b0, total_ff} + (TOTAL_BITS + 1)'(dist_ff);
   always_comb begin
      if (cur_ff.first_point) begin
         total_next = '0;
      end else if (total_sum[TOTAL_BITS]) begin
         total_next = '1;
      end else begin
         total_next = total_sum[TOTAL_BITS-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cur_in       = cur_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_z_in    = prev_z_ff;
      mag_in       = diff[COORD_BITS] ? diff_neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
      prod_in      = mag_ff * mag_ff;
      rad_in       = rad_ff;
      dist_in      = dist_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      // Leave z out of the sum in 2D mode; it is still stored as the
      // previous point.
      if ((step_ff == STEP_SQZ) && !three_dimensional_ff) begin
         prod_in = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cur_in  = req_payload;
               step_in = STEP_X;
               rad_in  = '0;
               if (req_payload.first_point) begin
                  dist_in  = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            if ((step_ff == STEP_Z) || (step_ff == STEP_SQZ)) begin
               rad_in = rad_sum;
            end
            if (step_ff == STEP_LAST) begin
               state_in = ST_ROOT;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_ROOT: begin
            if (sqrt_status.done) begin
               dist_in  = sqrt_root;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold here until the output register can take the response.
            if (rsp_free) begin
               total_in     = total_next;
               prev_x_in    = cur_ff.x_coord;
               prev_y_in    = cur_ff.y_coord;
               prev_z_in    = cur_ff.z_coord;
               rsp_valid_in = 1'b1;
               rsp_in.distance_out    = accumulate_mode_ff ? DIST_BITS'(total_next)
                                                           : DIST_BITS'(dist_ff);
               rsp_in.total_saturated = (total_next == '1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      rad_ff  <= rad_in;
      dist_ff <= dist_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         prev_z_ff    <= prev_z_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   psda_sqrt #(
      .RAD_W (RAD_BITS)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (rad_sum),
      .status   (sqrt_status),
      .root     (sqrt_root)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_stall_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while a point is in progress");

   a_root_in_root_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_status.done |-> (state_ff == ST_ROOT))
      else $error("square root finished outside the root state");

   a_saturated_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.total_saturated |-> (total_ff == '1))
      else $error("saturation flag without a saturated total");

   a_root_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) && !sqrt_status.done |-> sqrt_status.busy)
      else $error("waiting on an idle square root unit");

endmodule

`default_nettype wire

// ----- bench/path_step_distance_accumulator_tb.sv -----
`default_nettype none

module path_step_distance_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psda_pkg::*;

   // Run the block at the default width of the running total.
   localparam int TOTAL_W = TOTAL_BITS_DEF;
   localparam longint unsigned TOTAL_CEIL = (64'd1 << TOTAL_W) - 64'd1;

   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int ONE = 1 << 12;              // 1.0 in Q12.12

   localparam int HALF_PERIOD = 5;
   localparam int PHASES = 8;
   localparam int POINTS_PER_PHASE = 100;
   localparam int LINGER = 48;                // step latency plus margin
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic    reprogram;
      logic    accum;
      logic    three_d;
      logic    typed;
      rsp_type want;
      req_type pt;
   } plan_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_payload;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_ACCUMULATE_MODE;
   logic                      csr_wdata = 1'b0;

   // Shadow of the block: previous point, path length and mode registers.
   logic signed [COORD_BITS-1:0] prev_x = '0;
   logic signed [COORD_BITS-1:0] prev_y = '0;
   logic signed [COORD_BITS-1:0] prev_z = '0;
   longint unsigned              path_len = 0;
   logic                         mode_accum = 1'b0;
   logic                         mode_3d = 1'b1;

   rsp_type      pending_distances[$];
   plan_row_type directed_plan[$];

   // Directed rows carry their own expected response.
   logic    typed_on = 1'b0;
   rsp_type typed_rsp = '0;

   logic    no_idle = 1'b0;
   req_type last_pt = '0;
   int      path_scale = 4;

   int cycles = 0;
   int mismatches = 0;
   int checked = 0;
   int saturated_seen = 0;
   int points_sent = 0;
   int hold_left = 0;
   int run_left = 0;

   path_step_distance_accumulator #(
      .TOTAL_BITS(TOTAL_W)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Square of one coordinate difference; the difference needs one extra bit.
   function automatic longint unsigned gap_squared(logic signed [COORD_BITS-1:0] a,
                                                   logic signed [COORD_BITS-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return longint'(d * d);
   endfunction

   // Floor square root, one root bit at a time from the top. The radicand is
   // below 2^50, so the root fits in 26 bits and the trial square never wraps.
   function automatic longint unsigned floor_root(longint unsigned s);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = 26; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= s) r = c;
      end
      return r;
   endfunction

   // Advance the shadow by one point and return the response it must cause.
   function automatic rsp_type measure_step(req_type p);
      longint unsigned sum;
      longint unsigned step;
      rsp_type         r;
      step = 0;
      if (p.first_point) begin
         path_len = 0;
      end else begin
         sum = gap_squared(p.x_coord, prev_x) + gap_squared(p.y_coord, prev_y);
         if (mode_3d) sum += gap_squared(p.z_coord, prev_z);
         step = floor_root(sum);
         // Stick at the ceiling until the next first point.
         if (path_len > TOTAL_CEIL - step) path_len = TOTAL_CEIL;
         else path_len += step;
      end
      prev_x = p.x_coord;
      prev_y = p.y_coord;
      prev_z = p.z_coord;
      r.distance_out = DIST_BITS'(mode_accum ? path_len : step);
      r.total_saturated = (path_len == TOTAL_CEIL);
      return r;
   endfunction

   // Most gaps are short; a few are long, some outlasting a whole step.
   function automatic int idle_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Pick the next coordinate: mostly a walk from the previous one, sometimes
   // an arbitrary value or an extreme.
   function automatic logic signed [COORD_BITS-1:0] wander(
         logic signed [COORD_BITS-1:0] base, int scale);
      int pick;
      int span;
      int v;
      pick = $urandom_range(0, 15);
      span = 1 << scale;
      if (pick == 0) begin
         v = int'($urandom);
      end else if (pick == 1) begin
         case ($urandom_range(0, 3))
            0: v = COORD_MIN;
            1: v = COORD_MAX;
            2: v = 0;
            default: v = -1;
         endcase
      end else begin
         v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
         if (v < COORD_MIN) v = COORD_MIN;
         if (v > COORD_MAX) v = COORD_MAX;
      end
      return COORD_BITS'(v);
   endfunction

   task automatic plan_row(logic reprogram, logic accum, logic three_d, logic typed,
                           longint unsigned want_d, logic want_s,
                           int x, int y, int z, logic first);
      plan_row_type row;
      row.reprogram = reprogram;
      row.accum = accum;
      row.three_d = three_d;
      row.typed = typed;
      row.want.distance_out = DIST_BITS'(want_d);
      row.want.total_saturated = want_s;
      row.pt.x_coord = COORD_BITS'(x);
      row.pt.y_coord = COORD_BITS'(y);
      row.pt.z_coord = COORD_BITS'(z);
      row.pt.first_point = first;
      directed_plan.push_back(row);
   endtask

   // Enter and leave at a falling edge. Keep valid high across back-to-back
   // requests; drop it only for a gap.
   task automatic send_point(req_type p);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
      last_pt = p;
   endtask

   // Hold off the sender until every expected response is back.
   task automatic drain_requests();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_distances.size() != 0) @(negedge clock);
   endtask

   task automatic csr_put(logic [CSR_INDEX_BITS-1:0] idx, logic data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
   endtask

   // Program both mode bits, optionally after a write to an unused index
   // that the block must drop.
   task automatic program_mode(logic accum, logic three_d, logic stray);
      if (stray)
         csr_put(CSR_INDEX_BITS'($urandom_range(int'(CSR_THREE_DIMENSIONAL) + 1,
                                                (1 << CSR_INDEX_BITS) - 1)),
                 1'($urandom));
      csr_put(CSR_ACCUMULATE_MODE, accum);
      csr_put(CSR_THREE_DIMENSIONAL, three_d);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wander_phase(int count);
      req_type p;
      for (int k = 0; k < count; k++) begin
         p.first_point = ($urandom_range(0, 15) == 0);
         // A new path picks its step size; large steps grow the total fast.
         if (p.first_point)
            path_scale = ($urandom_range(0, 3) == 0) ? 22 : $urandom_range(0, 14);
         p.x_coord = wander(last_pt.x_coord, path_scale);
         p.y_coord = wander(last_pt.y_coord, path_scale);
         p.z_coord = wander(last_pt.z_coord, path_scale);
         send_point(p);
      end
   endtask

   // Receiver: alternate runs of acceptance with stalls of random length.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (run_left > 0) begin
         rsp_stall <= 1'b0;
         run_left--;
      end else begin
         rsp_stall <= 1'b0;
         run_left = $urandom_range(0, 12);
         hold_left = idle_gap();
      end
   end

   // Monitor: check responses, track register writes, predict each request.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_distances.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected response: distance %0d saturated %0b",
                           rsp_payload.distance_out, rsp_payload.total_saturated);
            end else begin
               want = pending_distances.pop_front();
               checked++;
               if (rsp_payload.total_saturated === 1'b1) saturated_seen++;
               if (rsp_payload.distance_out !== want.distance_out ||
                   rsp_payload.total_saturated !== want.total_saturated) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("response %0d: distance exp %0d got %0d, saturated exp %0b got %0b",
                              checked, want.distance_out, rsp_payload.distance_out,
                              want.total_saturated, rsp_payload.total_saturated);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCUMULATE_MODE:   mode_accum = csr_wdata;
               CSR_THREE_DIMENSIONAL: mode_3d = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = measure_step(req_payload);
            if (typed_on) want = typed_rsp;
            pending_distances.push_back(want);
            points_sent++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, pending_distances.size());
         $display("path_step_distance_accumulator test failed");
         $finish;
      end
   end

   initial begin
      // Reset modes first: step from the origin before any first point.
      plan_row(0, 0, 1, 1, 5 * ONE, 0, 3 * ONE, 4 * ONE, 0, 0);
      plan_row(0, 0, 1, 1, 0, 0, 0, 0, 0, 1);
      plan_row(0, 0, 1, 1, 12 * ONE, 0, 0, 0, 12 * ONE, 0);
      // Corner to corner of the coordinate cube: the largest steps there are.
      plan_row(0, 0, 1, 1, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN, 1);
      for (int i = 0; i < 11; i++) begin
         if (i % 2 == 0) plan_row(0, 0, 1, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0);
         else plan_row(0, 0, 1, 0, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0);
      end
      plan_row(1, 1, 1, 0, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0);
      // A first point clears the total.
      plan_row(0, 1, 1, 1, 0, 0, 0, 0, COORD_MAX, 1);
      // Plane mode: z jumps but adds nothing; z is still stored.
      plan_row(1, 1, 0, 1, 5 * ONE, 0, 3 * ONE, 4 * ONE, COORD_MIN, 0);
      plan_row(0, 1, 0, 1, 5 * ONE, 0, 3 * ONE, 4 * ONE, 0, 0);
      plan_row(1, 0, 1, 1, ONE, 0, 3 * ONE, 4 * ONE, ONE, 0);
      // Mode change within the path: the total kept running meanwhile.
      plan_row(1, 1, 1, 1, 6 * ONE, 0, 3 * ONE, 4 * ONE, ONE, 0);
      plan_row(0, 1, 1, 0, 0, 0, -1, -1, -1, 0);
      plan_row(0, 1, 1, 1, 0, 0, 1, 0, 0, 1);
      plan_row(0, 1, 1, 0, 0, 0, 1, COORD_MIN, COORD_MAX, 0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].reprogram) begin
            drain_requests();
            program_mode(directed_plan[i].accum, directed_plan[i].three_d, 1'b1);
         end
         typed_on = directed_plan[i].typed;
         typed_rsp = directed_plan[i].want;
         send_point(directed_plan[i].pt);
      end
      typed_on = 1'b0;

      // Walk every mode setting twice; one phase runs without any idling.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_requests();
         no_idle = (ph == 5);
         program_mode(ph[0], ph[1], 1'($urandom));
         wander_phase(POINTS_PER_PHASE);
      end

      drain_requests();
      repeat (LINGER) @(negedge clock);

      $display("covered %0d points (%0d directed) over %0d mode phases, all mode settings",
               points_sent, directed_plan.size(), PHASES + 1);
      $display("checked %0d responses, %0d with the total saturated, %0d mismatches",
               checked, saturated_seen, mismatches);
      if (mismatches == 0)
         $display("path_step_distance_accumulator test passed");
      else
         $display("path_step_distance_accumulator test failed");
      $finish;
   end

endmodule

`default_nettype wire
